// File: rtl/core/gtig_pkg.sv
`timescale 1ns / 1ps

package gtig_pkg;

    localparam int CFG_W  = 13;   // configuration register width
    localparam int IDX_W  = 26;   // vertex index width
    localparam int QCNT_W = 14;   // quad row / column counter width
    localparam int DIVD_W = 14;   // divider dividend / quotient width
    localparam int DIVS_W = 13;   // divider divisor / remainder width

    // register indexes on the configuration port
    localparam logic REG_GRID_WIDTH   = 1'b0;
    localparam logic REG_REGION_WIDTH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RPS,
        ST_MUL,
        ST_IDX,
        ST_EMIT,
        ST_DIV_COL
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [DIVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

// File: rtl/core/gtig_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module gtig_div (
    input  logic               clk,
    input  logic               rst_n,
    input  gtig_pkg::div_req_t req,
    output gtig_pkg::div_rsp_t rsp
);
    import gtig_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dsr_reg, dsr_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start && !busy_reg)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = CNT_W'(DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: rtl/core/grid_triangle_index_generator.sv
`timescale 1ns / 1ps

// Triangle index list generator for a square vertex grid tiled into square
// regions. Program grid_width (index 0) and region_width (index 1), both
// clamped to MAX_GRID_WIDTH, while the block is idle. A word with restart=1
// computes regions_per_side = ceil((grid_width-1)/(region_width-1)) and
// clears the walk; it yields no output and uses the 14-step shared
// divider. Each word with restart=0 yields one quad (two triangles, six
// indices) through the multiply, add and emit states; when the quad
// closes a region, the column-offset modulo then runs in the same
// divider. in_ready is high only while the sequencer is idle. final_quad
// marks the last quad; advance words after that give no output.
module grid_triangle_index_generator #(
    parameter int MAX_GRID_WIDTH = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_index,
    input  logic [gtig_pkg::CFG_W-1:0]   cfg_wr_data,
    // input word
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         restart,
    // output word
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gtig_pkg::IDX_W-1:0]   tri0_a,
    output logic [gtig_pkg::IDX_W-1:0]   tri0_b,
    output logic [gtig_pkg::IDX_W-1:0]   tri0_c,
    output logic [gtig_pkg::IDX_W-1:0]   tri1_a,
    output logic [gtig_pkg::IDX_W-1:0]   tri1_b,
    output logic [gtig_pkg::IDX_W-1:0]   tri1_c,
    output logic                         final_quad
);
    import gtig_pkg::*;

    // clamp limit, saturated to what the 13-bit registers can hold
    localparam logic [CFG_W-1:0] MAX_W =
        (MAX_GRID_WIDTH > (2 ** CFG_W) - 1) ? {CFG_W{1'b1}} : CFG_W'(MAX_GRID_WIDTH);

    // configuration
    logic [CFG_W-1:0] grid_width_reg, region_width_reg;

    // sequencer and walk state
    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  regions_reg, regions_next;
    logic [CFG_W-1:0]  region_row_reg, region_row_next;
    logic [CFG_W-1:0]  region_col_reg, region_col_next;
    logic [QCNT_W-1:0] quad_row_reg, quad_row_next;
    logic [QCNT_W-1:0] quad_col_reg, quad_col_next;
    logic [CFG_W-1:0]  col_offset_reg, col_offset_next;
    logic [QCNT_W-1:0] row_offset_reg, row_offset_next;
    logic              active_reg, active_next;

    // index datapath
    logic [IDX_W-1:0]  prod_reg, prod_next;
    logic [IDX_W-1:0]  top_reg, top_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  tri0_a_reg, tri0_a_next;
    logic [IDX_W-1:0]  tri0_b_reg, tri0_b_next;
    logic [IDX_W-1:0]  tri0_c_reg, tri0_c_next;
    logic [IDX_W-1:0]  tri1_c_reg, tri1_c_next;
    logic              final_reg, final_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [CFG_W-1:0]  w_cl, r_cl, q, wm1;
    logic              widths_ok;
    logic              in_fire, emit_fire;
    logic [QCNT_W:0]   z, x;
    logic [2*QCNT_W-1:0] prod_full;
    logic [IDX_W-1:0]  bot, bot_p1, top_p1;

    // walk step (used in emit)
    logic [QCNT_W-1:0] qc1, qr1;
    logic [CFG_W-1:0]  rc1, rr1;
    logic              col_wrap, row_wrap, reg_col_wrap, reg_row_wrap;

    gtig_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= CFG_W'(2);
            region_width_reg <= CFG_W'(2);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                REG_GRID_WIDTH:   grid_width_reg   <= cfg_wr_data;
                REG_REGION_WIDTH: region_width_reg <= cfg_wr_data;
                default:          ;
            endcase
        end
    end

    assign w_cl      = (grid_width_reg > MAX_W) ? MAX_W : grid_width_reg;
    assign r_cl      = (region_width_reg > MAX_W) ? MAX_W : region_width_reg;
    assign q         = r_cl - 1'b1;
    assign wm1       = w_cl - 1'b1;
    assign widths_ok = (w_cl >= CFG_W'(2)) && (r_cl >= CFG_W'(2));

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    // emit waits for a free output slot
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // vertex coordinates and products
    assign z         = {1'b0, row_offset_reg} + {1'b0, quad_row_reg};
    assign x         = {2'b0, col_offset_reg} + {1'b0, quad_col_reg};
    assign prod_full = {{(QCNT_W-1){1'b0}}, z} * {{(2*QCNT_W-CFG_W){1'b0}}, w_cl};
    assign bot       = top_reg + {{(IDX_W-CFG_W){1'b0}}, w_cl};
    assign bot_p1    = bot + IDX_W'(1);
    assign top_p1    = top_reg + IDX_W'(1);

    // counter cascade: column, row, region column, region row
    assign qc1          = quad_col_reg + 1'b1;
    assign qr1          = quad_row_reg + 1'b1;
    assign rc1          = region_col_reg + 1'b1;
    assign rr1          = region_row_reg + 1'b1;
    assign col_wrap     = qc1 >= {1'b0, q};
    assign row_wrap     = col_wrap && (qr1 >= {1'b0, q});
    assign reg_col_wrap = row_wrap && (rc1 >= regions_reg);
    assign reg_row_wrap = reg_col_wrap && (rr1 >= regions_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (restart)
                    begin
                        if (widths_ok)
                            state_next = ST_DIV_RPS;
                    end
                    else if (active_reg && widths_ok && (regions_reg != '0))
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DIV_RPS:
            begin
                if (div_rsp.done)
                    state_next = ST_IDLE;
            end
            ST_MUL:
                state_next = ST_IDX;
            ST_IDX:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_fire)
                    state_next = row_wrap ? ST_DIV_COL : ST_IDLE;
            end
            ST_DIV_COL:
            begin
                if (div_rsp.done)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and walk updates
    always_comb
    begin
        regions_next    = regions_reg;
        region_row_next = region_row_reg;
        region_col_next = region_col_reg;
        quad_row_next   = quad_row_reg;
        quad_col_next   = quad_col_reg;
        col_offset_next = col_offset_reg;
        row_offset_next = row_offset_reg;
        active_next     = active_reg;
        prod_next       = prod_reg;
        top_next        = top_reg;
        tri0_a_next     = tri0_a_reg;
        tri0_b_next     = tri0_b_reg;
        tri0_c_next     = tri0_c_reg;
        tri1_c_next     = tri1_c_reg;
        final_next      = final_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, wm1} + {1'b0, q} - 1'b1;
        div_req.divisor  = q;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (restart)
                    begin
                        region_row_next = '0;
                        region_col_next = '0;
                        quad_row_next   = '0;
                        quad_col_next   = '0;
                        col_offset_next = '0;
                        row_offset_next = '0;
                        if (widths_ok)
                        begin
                            // ceil((w-1)/q) as ((w-1)+(q-1))/q
                            div_req.start = 1'b1;
                        end
                        else
                        begin
                            regions_next = '0;
                            active_next  = 1'b0;
                        end
                    end
                    else if (!(active_reg && widths_ok && (regions_reg != '0)))
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            ST_DIV_RPS:
            begin
                if (div_rsp.done)
                begin
                    regions_next = div_rsp.quotient[CFG_W-1:0];
                    active_next  = (div_rsp.quotient[CFG_W-1:0] != '0);
                end
            end
            ST_MUL:
                prod_next = prod_full[IDX_W-1:0];
            ST_IDX:
                top_next = prod_reg + {{(IDX_W-QCNT_W-1){1'b0}}, x};
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    tri0_a_next    = top_reg;
                    tri0_b_next    = bot;
                    tri0_c_next    = bot_p1;
                    tri1_c_next    = top_p1;
                    final_next     = reg_row_wrap;

                    quad_col_next = col_wrap ? '0 : qc1;
                    if (col_wrap)
                        quad_row_next = row_wrap ? '0 : qr1;
                    if (row_wrap)
                    begin
                        // (col_offset + q) mod (w - 1) in the divider
                        div_req.start    = 1'b1;
                        div_req.dividend = {1'b0, col_offset_reg} + {1'b0, q};
                        div_req.divisor  = wm1;
                        region_col_next  = reg_col_wrap ? '0 : rc1;
                    end
                    if (reg_col_wrap)
                    begin
                        row_offset_next = row_offset_reg + {1'b0, q};
                        region_row_next = rr1;
                    end
                    if (reg_row_wrap)
                        active_next = 1'b0;
                end
            end
            ST_DIV_COL:
            begin
                if (div_rsp.done)
                    col_offset_next = div_rsp.remainder;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            regions_reg    <= '0;
            region_row_reg <= '0;
            region_col_reg <= '0;
            quad_row_reg   <= '0;
            quad_col_reg   <= '0;
            col_offset_reg <= '0;
            row_offset_reg <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            regions_reg    <= regions_next;
            region_row_reg <= region_row_next;
            region_col_reg <= region_col_next;
            quad_row_reg   <= quad_row_next;
            quad_col_reg   <= quad_col_next;
            col_offset_reg <= col_offset_next;
            row_offset_reg <= row_offset_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        top_reg    <= top_next;
        tri0_a_reg <= tri0_a_next;
        tri0_b_reg <= tri0_b_next;
        tri0_c_reg <= tri0_c_next;
        tri1_c_reg <= tri1_c_next;
        final_reg  <= final_next;
    end

    assign out_valid  = out_valid_reg;
    assign tri0_a     = tri0_a_reg;
    assign tri0_b     = tri0_b_reg;
    assign tri0_c     = tri0_c_reg;
    assign tri1_a     = tri0_a_reg;
    assign tri1_b     = tri0_c_reg;
    assign tri1_c     = tri1_c_reg;
    assign final_quad = final_reg;

    // a quad is only ever emitted from a live sequence
    a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> active_reg)
        else $error("emit without active sequence");

    // a live sequence always has a nonzero region count
    a_active_regions: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (regions_reg != '0))
        else $error("active sequence with zero regions");

    // the divider is idle whenever a new word is taken
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !div_rsp.busy)
        else $error("word accepted while divider busy");

endmodule

// File: tb/sv/grid_triangle_index_checker.sv
`timescale 1ns / 1ps

module grid_triangle_index_checker #(
    parameter int MAX_GRID_WIDTH = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_index,
    input  logic [gtig_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         restart,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [gtig_pkg::IDX_W-1:0]   tri0_a,
    input  logic [gtig_pkg::IDX_W-1:0]   tri0_b,
    input  logic [gtig_pkg::IDX_W-1:0]   tri0_c,
    input  logic [gtig_pkg::IDX_W-1:0]   tri1_a,
    input  logic [gtig_pkg::IDX_W-1:0]   tri1_b,
    input  logic [gtig_pkg::IDX_W-1:0]   tri1_c,
    input  logic                         final_quad,
    output int                           mismatches,
    output int                           quads_pending
);

    import gtig_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] t0a;
        logic [IDX_W-1:0] t0b;
        logic [IDX_W-1:0] t0c;
        logic [IDX_W-1:0] t1a;
        logic [IDX_W-1:0] t1b;
        logic [IDX_W-1:0] t1c;
        logic             last;
    } quad_word_t;

    quad_word_t quads_due[$];

    // shadow of the configuration registers and of the walk counters
    logic [CFG_W-1:0]  grid_w;
    logic [CFG_W-1:0]  region_w;
    logic [CFG_W-1:0]  rps;
    logic [CFG_W-1:0]  region_row;
    logic [CFG_W-1:0]  region_col;
    logic [QCNT_W-1:0] quad_row;
    logic [QCNT_W-1:0] quad_col;
    logic [CFG_W-1:0]  col_offset;
    logic [QCNT_W-1:0] row_offset;
    bit                walk_active;

    task automatic walk_word(input logic rs);
        int unsigned     w;
        int unsigned     r;
        int unsigned     q;
        longint unsigned z;
        longint unsigned x;
        longint unsigned top;
        longint unsigned bot;
        quad_word_t      e;
        w = (grid_w > MAX_GRID_WIDTH) ? MAX_GRID_WIDTH : grid_w;
        r = (region_w > MAX_GRID_WIDTH) ? MAX_GRID_WIDTH : region_w;
        if (rs)
        begin
            region_row = '0;
            region_col = '0;
            quad_row   = '0;
            quad_col   = '0;
            col_offset = '0;
            row_offset = '0;
            if (w < 2 || r < 2)
                rps = '0;
            else
            begin
                q   = r - 1;
                rps = CFG_W'(((w - 1) + (q - 1)) / q);
            end
            walk_active = (rps != 0);
            return;
        end
        if (!walk_active || w < 2 || r < 2 || rps == 0)
        begin
            walk_active = 0;
            return;
        end
        q   = r - 1;
        z   = longint'(row_offset) + quad_row;
        x   = longint'(col_offset) + quad_col;
        top = z * w + x;
        bot = (z + 1) * w + x;
        e.t0a = IDX_W'(top);
        e.t0b = IDX_W'(bot);
        e.t0c = IDX_W'(bot + 1);
        e.t1a = IDX_W'(top);
        e.t1b = IDX_W'(bot + 1);
        e.t1c = IDX_W'(top + 1);
        quad_col = quad_col + 1'b1;
        if (quad_col >= q)
        begin
            quad_col = '0;
            quad_row = quad_row + 1'b1;
            if (quad_row >= q)
            begin
                quad_row   = '0;
                col_offset = CFG_W'((col_offset + q) % (w - 1));
                region_col = region_col + 1'b1;
                if (region_col >= rps)
                begin
                    region_col = '0;
                    row_offset = QCNT_W'(row_offset + q);
                    region_row = region_row + 1'b1;
                    if (region_row >= rps)
                        walk_active = 0;
                end
            end
        end
        e.last = !walk_active;
        quads_due.push_back(e);
    endtask

    task automatic check_field(input string label, input logic [IDX_W-1:0] want,
                               input logic [IDX_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        quad_word_t e;
        if (!rst_n)
        begin
            grid_w      = CFG_W'(2);
            region_w    = CFG_W'(2);
            rps         = '0;
            region_row  = '0;
            region_col  = '0;
            quad_row    = '0;
            quad_col    = '0;
            col_offset  = '0;
            row_offset  = '0;
            walk_active = 0;
            mismatches  = 0;
            quads_due.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_wr_index == REG_GRID_WIDTH)
                    grid_w = cfg_wr_data;
                else
                    region_w = cfg_wr_data;
            end
            if (out_valid && out_ready)
            begin
                if (quads_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none actual %0d %0d %0d",
                             $time, tri0_a, tri0_b, tri0_c);
                    mismatches++;
                end
                else
                begin
                    e = quads_due.pop_front();
                    check_field("tri0_a", e.t0a, tri0_a);
                    check_field("tri0_b", e.t0b, tri0_b);
                    check_field("tri0_c", e.t0c, tri0_c);
                    check_field("tri1_a", e.t1a, tri1_a);
                    check_field("tri1_b", e.t1b, tri1_b);
                    check_field("tri1_c", e.t1c, tri1_c);
                    check_field("final_quad", IDX_W'(e.last), IDX_W'(final_quad));
                end
            end
            if (in_valid && in_ready)
                walk_word(restart);
        end
        quads_pending = quads_due.size();
    end

endmodule

// File: tb/sv/grid_triangle_index_generator_tb.sv
`timescale 1ns / 1ps

module grid_triangle_index_generator_tb;

    import gtig_pkg::*;

    localparam int LIMIT_CYCLES = 400000;  // far above the slowest legal run
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int HOLD_AFTER   = 25;      // results seen before the hold-off
    localparam int TOTAL_WORDS  = 620;     // directed + random
    localparam int CALM_AFTER   = 500;     // no idling past this word count
    localparam int SETTLE       = 40;      // restart divide or region-close modulo

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic                  cfg_wr_index;
    logic [CFG_W-1:0]      cfg_wr_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  restart;
    logic                  out_valid;
    logic                  out_ready;
    logic [IDX_W-1:0]      tri0_a;
    logic [IDX_W-1:0]      tri0_b;
    logic [IDX_W-1:0]      tri0_c;
    logic [IDX_W-1:0]      tri1_a;
    logic [IDX_W-1:0]      tri1_b;
    logic [IDX_W-1:0]      tri1_c;
    logic                  final_quad;

    int                    mismatches;
    int                    quads_pending;
    int                    results_taken = 0;
    int unsigned           idle_rate = 0;   // percent chance of a sender gap
    int unsigned           words_sent = 0;
    bit                    calm = 0;        // final stretch: nobody idles

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    grid_triangle_index_generator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tri0_a       (tri0_a),
        .tri0_b       (tri0_b),
        .tri0_c       (tri0_c),
        .tri1_a       (tri1_a),
        .tri1_b       (tri1_b),
        .tri1_c       (tri1_c),
        .final_quad   (final_quad)
    );

    // Predicts every quad from the observed handshakes and config writes.
    grid_triangle_index_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tri0_a        (tri0_a),
        .tri0_b        (tri0_b),
        .tri0_c        (tri0_c),
        .tri1_a        (tri1_a),
        .tri1_b        (tri1_b),
        .tri1_c        (tri1_c),
        .final_quad    (final_quad),
        .mismatches    (mismatches),
        .quads_pending (quads_pending)
    );

    // Watchdog: a hung handshake ends the run here.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= LIMIT_CYCLES)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    always @(posedge clk)
        if (out_valid && out_ready)
            results_taken <= results_taken + 1;

    // Receiver. Stall density drifts over time (zero included, so there are
    // clean stretches). Once, after a few results, it holds off for a long
    // stretch so the block backs up and drops in_ready while the sender keeps
    // offering words.
    initial
    begin : receiver
        int unsigned stall_rate;
        bit          hold_done;
        stall_rate = 0;
        hold_done  = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_taken >= HOLD_AFTER)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < stall_rate)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
            if ($urandom_range(0, 63) == 0)
                stall_rate = $urandom_range(0, 3) * 15;
        end
    end

    // One word on the input channel. Valid stays high after acceptance so
    // back-to-back words need no extra NBA on in_valid in the same step.
    task automatic send_word(input logic rs);
        if (!calm && $urandom_range(0, 99) < idle_rate)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        words_sent++;
    endtask

    // Advance words; a rare restart among them breaks the walk on purpose.
    task automatic advance(input int unsigned n, input bit noisy);
        repeat (n) send_word(noisy && $urandom_range(0, 39) == 0);
    endtask

    // Drop valid, wait until every predicted quad is out, then let the block
    // finish any divide that produces no word before touching the config.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (quads_pending != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic program_widths(input int unsigned grid, input int unsigned region);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_GRID_WIDTH;
        cfg_wr_data  <= CFG_W'(grid);
        @(negedge clk);
        cfg_wr_index <= REG_REGION_WIDTH;
        cfg_wr_data  <= CFG_W'(region);
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
    endtask

    function automatic int unsigned edge_width();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return 4096;
            4: return 8191;
            default: return $urandom_range(0, 8191);
        endcase
    endfunction

    initial
    begin : stimulus
        int unsigned grid;
        int unsigned region;
        int unsigned q;
        int unsigned rps;
        int unsigned quads;
        int unsigned pick;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_GRID_WIDTH;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        restart      = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed ---
        // 3x3 grid of 2x2 regions: four quads, advance before and after the list
        program_widths(3, 2);
        send_word(1'b0);
        send_word(1'b1);
        advance(5, 0);
        settle();
        // zero grid width: empty list, advance gives nothing
        program_widths(0, 5);
        send_word(1'b1);
        advance(1, 0);
        settle();
        // region width of one: empty list
        program_widths(6, 1);
        send_word(1'b1);
        advance(1, 0);
        settle();
        // both widths above the max: clamped to one huge region
        program_widths(8191, 8191);
        send_word(1'b1);
        advance(2, 0);
        settle();
        // widest grid, smallest regions: every quad closes a region
        program_widths(4096, 2);
        send_word(1'b1);
        advance(3, 0);
        settle();
        // config swapped in the middle of a walk, then collapsed below two
        program_widths(5, 3);
        send_word(1'b1);
        advance(2, 0);
        settle();
        program_widths(9, 2);
        advance(3, 0);
        settle();
        program_widths(1, 2);
        advance(2, 0);
        settle();

        // --- random phases ---
        while (words_sent < TOTAL_WORDS)
        begin
            calm      = (words_sent >= CALM_AFTER);
            idle_rate = calm ? 0 : $urandom_range(0, 3) * 20;
            pick      = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // odd or extreme widths, a short burst of quads
                program_widths(edge_width(), edge_width());
                send_word(1'b1);
                advance($urandom_range(1, 8), 1);
            end
            else
            begin
                grid   = $urandom_range(2, 10);
                region = $urandom_range(2, 6);
                program_widths(grid, region);
                if (pick == 1)
                    // carry on a walk left open by an earlier phase
                    advance($urandom_range(1, 30), 0);
                else
                begin
                    q     = region - 1;
                    rps   = (grid - 1 + q - 1) / q;
                    quads = rps * rps * q * q;
                    send_word(1'b1);
                    if ($urandom_range(0, 4) == 0)
                        advance($urandom_range(1, quads), 0);
                    else
                        advance(quads + $urandom_range(0, 2), pick == 2);
                end
            end
            settle();
        end

        // every word already accepted and drained; a short tail for stragglers
        repeat (50) @(negedge clk);
        if (mismatches == 0 && quads_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/gtig_pkg.sv
rtl/core/gtig_div.sv
rtl/core/grid_triangle_index_generator.sv
tb/sv/grid_triangle_index_checker.sv
tb/sv/grid_triangle_index_generator_tb.sv
